// File: sv/tslru_pkg.sv
`default_nettype none

package tslru_pkg;

	localparam int SLOTS     = 64;
	localparam int IDX_W     = $clog2(SLOTS);
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int STAMP_W   = 32;
	localparam int ZOOM_W    = 5;
	localparam int FUNC_W    = 3;
	localparam int ST_W      = 2;
	localparam int OUT_W     = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ZOOM     = 1'b1;

	localparam logic [CFG_W-1:0]  SLOTS_RESET    = 7'd64;
	localparam logic [ZOOM_W-1:0] MAX_ZOOM_RESET = 5'd20;

	typedef enum logic [FUNC_W-1:0] {
		FN_BEGIN_FRAME = 3'd0,
		FN_FIND_READY  = 3'd1,
		FN_FIND_ANY    = 3'd2,
		FN_TOUCH       = 3'd3,
		FN_ACQUIRE     = 3'd4,
		FN_COMMIT      = 3'd5,
		FN_RELEASE     = 3'd6,
		FN_RESET       = 3'd7
	} func_t;

	typedef enum logic [ST_W-1:0] {
		ST_FREE    = 2'd0,
		ST_LOADING = 2'd1,
		ST_READY   = 2'd2
	} slot_st_t;

	typedef enum logic [1:0] {
		RS_OK       = 2'd0,
		RS_ARG      = 2'd1,
		RS_FULL     = 2'd2,
		RS_NOTFOUND = 2'd3
	} rs_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	// write side of the slot memory and its valid bits
	typedef struct packed {
		logic             we;
		logic             clr_one;
		logic             clr_all;
		logic [IDX_W-1:0] addr;
	} mem_cmd_t;

	// what one scan over the slots in use leaves behind
	typedef struct packed {
		logic [CNT_W-1:0] n_free;
		logic [CNT_W-1:0] n_load;
		logic [CNT_W-1:0] n_ready;
		logic             hit_any;
		logic [IDX_W-1:0] hit_any_idx;
		logic             hit_rdy;
		logic [IDX_W-1:0] hit_rdy_idx;
		logic             free_ok;
		logic [IDX_W-1:0] free_idx;
		logic             old_ok;
		logic [IDX_W-1:0] old_idx;
		slot_st_t         tgt_st;
	} scan_res_t;

endpackage

`default_nettype wire

// File: sv/tslru_slot_mem.sv
`default_nettype none

module tslru_slot_mem #(
	parameter int ENT_W = 79
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire tslru_pkg::mem_cmd_t    cmd,
	input  wire  [ENT_W-1:0]            wdata,
	input  wire                         rd_en,
	input  wire  [tslru_pkg::IDX_W-1:0] rd_addr,
	output logic                        rd_ok,
	output logic                        rd_vld,
	output logic [ENT_W-1:0]            rd_data
);

	logic [ENT_W-1:0]            mem_q [tslru_pkg::SLOTS];
	logic [tslru_pkg::SLOTS-1:0] vld_q;
	logic                        rd_ok_q;
	logic                        rd_vld_q;
	logic [ENT_W-1:0]            rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.we)
			mem_q[cmd.addr] <= wdata;
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	// an entry without its valid bit reads as a free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_ok_q  <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_ok_q  <= rd_en;
			rd_vld_q <= rd_en & vld_q[rd_addr];
			if (cmd.clr_all)
				vld_q <= '0;
			else if (cmd.we)
				vld_q[cmd.addr] <= 1'b1;
			else if (cmd.clr_one)
				vld_q[cmd.addr] <= 1'b0;
		end
	end

	assign rd_ok   = rd_ok_q;
	assign rd_vld  = rd_vld_q;
	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: sv/tslru_scan.sv
`default_nettype none

module tslru_scan #(
	parameter int KEY_W = 45,
	parameter int ENT_W = 79
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         clear,
	input  wire                         en,
	input  wire  [tslru_pkg::IDX_W-1:0] addr,
	input  wire                         ent_vld,
	input  wire  [ENT_W-1:0]            ent,
	input  wire  [KEY_W-1:0]            key_ref,
	input  wire  [tslru_pkg::IDX_W-1:0] tgt_idx,
	output tslru_pkg::scan_res_t        res,
	output logic [KEY_W-1:0]            tgt_key
);

	localparam int SW = tslru_pkg::STAMP_W;
	localparam int CW = tslru_pkg::CNT_W;
	localparam int IW = tslru_pkg::IDX_W;

	tslru_pkg::slot_st_t st;
	logic [KEY_W-1:0]    key;
	logic [SW-1:0]       stamp;
	logic                key_hit;

	logic [CW-1:0]       n_free_q, n_load_q, n_ready_q;
	logic                hit_any_q, hit_rdy_q, free_ok_q, old_ok_q;
	logic [IW-1:0]       hit_any_idx_q, hit_rdy_idx_q, free_idx_q, old_idx_q;
	logic [SW-1:0]       old_stamp_q;
	tslru_pkg::slot_st_t tgt_st_q;
	logic [KEY_W-1:0]    tgt_key_q;

	assign st      = ent_vld ? tslru_pkg::slot_st_t'(ent[ENT_W-1 -: tslru_pkg::ST_W])
	                         : tslru_pkg::ST_FREE;
	assign key     = ent[SW +: KEY_W];
	assign stamp   = ent[SW-1:0];
	assign key_hit = (key == key_ref);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_free_q  <= '0;
			n_load_q  <= '0;
			n_ready_q <= '0;
			hit_any_q <= 1'b0;
			hit_rdy_q <= 1'b0;
			free_ok_q <= 1'b0;
			old_ok_q  <= 1'b0;
		end else if (clear) begin
			n_free_q  <= '0;
			n_load_q  <= '0;
			n_ready_q <= '0;
			hit_any_q <= 1'b0;
			hit_rdy_q <= 1'b0;
			free_ok_q <= 1'b0;
			old_ok_q  <= 1'b0;
		end else if (en) begin
			unique case (st)
				tslru_pkg::ST_FREE:    n_free_q  <= n_free_q + CW'(1);
				tslru_pkg::ST_LOADING: n_load_q  <= n_load_q + CW'(1);
				tslru_pkg::ST_READY:   n_ready_q <= n_ready_q + CW'(1);
				default: ;
			endcase
			if (st != tslru_pkg::ST_FREE && key_hit)
				hit_any_q <= 1'b1;
			if (st == tslru_pkg::ST_READY && key_hit)
				hit_rdy_q <= 1'b1;
			if (st == tslru_pkg::ST_FREE)
				free_ok_q <= 1'b1;
			if (st == tslru_pkg::ST_READY)
				old_ok_q <= 1'b1;
		end
	end

	// first match wins; the oldest stamp is replaced only on a strictly smaller one
	always_ff @(posedge clk) begin
		if (en) begin
			if (!hit_any_q && st != tslru_pkg::ST_FREE && key_hit)
				hit_any_idx_q <= addr;
			if (!hit_rdy_q && st == tslru_pkg::ST_READY && key_hit)
				hit_rdy_idx_q <= addr;
			if (!free_ok_q && st == tslru_pkg::ST_FREE)
				free_idx_q <= addr;
			if (st == tslru_pkg::ST_READY && (!old_ok_q || stamp < old_stamp_q)) begin
				old_idx_q   <= addr;
				old_stamp_q <= stamp;
			end
			if (addr == tgt_idx) begin
				tgt_st_q  <= st;
				tgt_key_q <= key;
			end
		end
	end

	always_comb begin
		res.n_free      = n_free_q;
		res.n_load      = n_load_q;
		res.n_ready     = n_ready_q;
		res.hit_any     = hit_any_q;
		res.hit_any_idx = hit_any_idx_q;
		res.hit_rdy     = hit_rdy_q;
		res.hit_rdy_idx = hit_rdy_idx_q;
		res.free_ok     = free_ok_q;
		res.free_idx    = free_idx_q;
		res.old_ok      = old_ok_q;
		res.old_idx     = old_idx_q;
		res.tgt_st      = tgt_st_q;
	end

	assign tgt_key = tgt_key_q;

endmodule

`default_nettype wire

// File: sv/tile_slot_cache_lru_unit.sv
// Tile slot cache with least-recently-used replacement.
// Requests enter on the s_axis channel: tuser carries the operation code, tdata the
// tile key and slot index. Each request gives exactly one result on m_axis: status,
// found flag, slot number and the free/loading/ready counts after the operation.
// Configuration (slots in use, maximum zoom) is written through cfg_we/cfg_index/
// cfg_data; the user must do so while no request is in flight, which is not enforced.
// Slot state, key and stamp live in one single-port-read synchronous memory. Every
// request scans slots 0..n-1, one read per cycle, with n = min(slots_in_use, 64),
// then writes back at most one entry (a reset request clears all valid bits instead).
// A new request is accepted only after the previous one has passed its write-back;
// the scan through the single memory read port sets how long each request takes.
// A finished result waits in the output register; the next request is accepted and
// scanned meanwhile, and holds before its write-back until the receiver takes the
// earlier result, so m_axis_tready low stalls the block without losing anything.
// Reset frees all slots at once through per-slot valid bits (no clearing pass), sets
// the frame counter to one and loads the register defaults (64 slots, zoom 20).
`default_nettype none

module tile_slot_cache_lru_unit #(
	parameter int COORD_BITS = 20,
	localparam int IN_W = ((2 * COORD_BITS + tslru_pkg::ZOOM_W + tslru_pkg::IDX_W + 7) / 8) * 8
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [tslru_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [tslru_pkg::CFG_W-1:0]      cfg_data,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [tslru_pkg::FUNC_W-1:0]     s_axis_tuser,  // func
	input  wire  [IN_W-1:0]                  s_axis_tdata,  // tile_x, tile_y, tile_zoom, slot_index
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// status, found, slot_number, free_count, loading_count, ready_count
	output logic [tslru_pkg::OUT_W-1:0]      m_axis_tdata
);

	localparam int CB    = COORD_BITS;
	localparam int ZW    = tslru_pkg::ZOOM_W;
	localparam int IW    = tslru_pkg::IDX_W;
	localparam int CW    = tslru_pkg::CNT_W;
	localparam int SW    = tslru_pkg::STAMP_W;
	localparam int KEY_W = 2 * CB + ZW;
	localparam int ENT_W = tslru_pkg::ST_W + KEY_W + SW;
	localparam int RES_W = 2 + 1 + IW + 3 * CW;

	tslru_pkg::state_t    state_q, state_d;
	logic [CW-1:0]        slots_q;
	logic [ZW-1:0]        max_zoom_q;
	logic [CW-1:0]        n_act;
	logic [SW-1:0]        frame_q;

	tslru_pkg::func_t     func_q;
	logic [CB-1:0]        x_q, y_q;
	logic [ZW-1:0]        zoom_q;
	logic [IW-1:0]        idx_q;
	logic [KEY_W-1:0]     key_q;

	logic                 accept, issue, scan_done, can_fin, fin_fire;
	logic [CW-1:0]        rd_addr_q;
	logic [IW-1:0]        addr_s1;

	logic                 rd_ok, rd_vld;
	logic [ENT_W-1:0]     rd_data;
	tslru_pkg::mem_cmd_t  mem_cmd;
	logic [ENT_W-1:0]     wdata;

	tslru_pkg::scan_res_t sres;
	logic [KEY_W-1:0]     tgt_key;

	logic                 tile_ok, idx_ok;
	logic                 want_we, want_clr_one, want_clr_all, frame_inc;
	logic [IW-1:0]        waddr;
	tslru_pkg::rs_t       status_d;
	logic                 found_d;
	logic [IW-1:0]        slot_d;
	logic [CW-1:0]        nf_d, nl_d, nr_d;

	logic                 out_vld_q;
	tslru_pkg::rs_t       out_status_q;
	logic                 out_found_q;
	logic [IW-1:0]        out_slot_q;
	logic [CW-1:0]        out_free_q, out_load_q, out_ready_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q    <= tslru_pkg::SLOTS_RESET;
			max_zoom_q <= tslru_pkg::MAX_ZOOM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == tslru_pkg::CFG_SLOTS_IN_USE)
				slots_q <= cfg_data;
			else
				max_zoom_q <= cfg_data[ZW-1:0];
		end
	end

	assign n_act = (slots_q > CW'(tslru_pkg::SLOTS)) ? CW'(tslru_pkg::SLOTS) : slots_q;

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tslru_pkg::S_IDLE:   if (s_axis_tvalid) state_d = tslru_pkg::S_SCAN;
			tslru_pkg::S_SCAN:   if (scan_done) state_d = tslru_pkg::S_FINISH;
			tslru_pkg::S_FINISH: if (can_fin) state_d = tslru_pkg::S_IDLE;
			default:             state_d = tslru_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == tslru_pkg::S_IDLE);
		accept        = s_axis_tready && s_axis_tvalid;
		issue         = (state_q == tslru_pkg::S_SCAN) && (rd_addr_q < n_act);
		scan_done     = (state_q == tslru_pkg::S_SCAN) && !issue && !rd_ok;
		can_fin       = !out_vld_q || m_axis_tready;
		fin_fire      = (state_q == tslru_pkg::S_FINISH) && can_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tslru_pkg::S_IDLE;
			rd_addr_q <= '0;
			frame_q   <= SW'(1);
		end else begin
			state_q <= state_d;
			if (accept)
				rd_addr_q <= '0;
			else if (issue)
				rd_addr_q <= rd_addr_q + CW'(1);
			if (fin_fire && frame_inc)
				frame_q <= frame_q + SW'(1);
		end
	end

	// request capture and read address pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= tslru_pkg::func_t'(s_axis_tuser);
			x_q    <= s_axis_tdata[CB-1:0];
			y_q    <= s_axis_tdata[2*CB-1:CB];
			zoom_q <= s_axis_tdata[2*CB +: ZW];
			idx_q  <= s_axis_tdata[2*CB+ZW +: IW];
		end
		addr_s1 <= rd_addr_q[IW-1:0];
	end

	assign key_q = {zoom_q, y_q, x_q};

	tslru_slot_mem #(
		.ENT_W (ENT_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (mem_cmd),
		.wdata   (wdata),
		.rd_en   (issue),
		.rd_addr (rd_addr_q[IW-1:0]),
		.rd_ok   (rd_ok),
		.rd_vld  (rd_vld),
		.rd_data (rd_data)
	);

	tslru_scan #(
		.KEY_W (KEY_W),
		.ENT_W (ENT_W)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (accept),
		.en      (rd_ok),
		.addr    (addr_s1),
		.ent_vld (rd_vld),
		.ent     (rd_data),
		.key_ref (key_q),
		.tgt_idx (idx_q),
		.res     (sres),
		.tgt_key (tgt_key)
	);

	// zoom must not exceed the maximum zoom, and x and y must stay below 2^zoom
	always_comb begin
		tile_ok = (zoom_q <= max_zoom_q);
		for (int i = 0; i < CB; i++) begin
			if (i >= int'(zoom_q) && (x_q[i] || y_q[i]))
				tile_ok = 1'b0;
		end
	end

	assign idx_ok = ({1'b0, idx_q} < n_act);

	// decide the write-back and the result from the scan
	always_comb begin
		want_we      = 1'b0;
		want_clr_one = 1'b0;
		want_clr_all = 1'b0;
		frame_inc    = 1'b0;
		waddr        = idx_q;
		wdata        = {tslru_pkg::ST_LOADING, key_q, frame_q};
		status_d     = tslru_pkg::RS_OK;
		found_d      = 1'b0;
		slot_d       = '0;
		nf_d         = sres.n_free;
		nl_d         = sres.n_load;
		nr_d         = sres.n_ready;
		unique case (func_q)
			tslru_pkg::FN_BEGIN_FRAME: frame_inc = 1'b1;
			tslru_pkg::FN_FIND_READY: begin
				if (sres.hit_rdy) begin
					found_d = 1'b1;
					slot_d  = sres.hit_rdy_idx;
				end else begin
					status_d = tslru_pkg::RS_NOTFOUND;
				end
			end
			tslru_pkg::FN_FIND_ANY: begin
				if (sres.hit_any) begin
					found_d = 1'b1;
					slot_d  = sres.hit_any_idx;
				end else begin
					status_d = tslru_pkg::RS_NOTFOUND;
				end
			end
			tslru_pkg::FN_TOUCH: begin
				if (!idx_ok) begin
					status_d = tslru_pkg::RS_ARG;
				end else begin
					want_we = 1'b1;
					wdata   = {sres.tgt_st, tgt_key, frame_q};
				end
			end
			tslru_pkg::FN_ACQUIRE: begin
				priority if (!tile_ok) begin
					status_d = tslru_pkg::RS_ARG;
				end else if (sres.hit_any) begin
					found_d = 1'b1;
					slot_d  = sres.hit_any_idx;
				end else if (sres.free_ok) begin
					found_d = 1'b1;
					slot_d  = sres.free_idx;
					waddr   = sres.free_idx;
					want_we = 1'b1;
					nf_d    = sres.n_free - CW'(1);
					nl_d    = sres.n_load + CW'(1);
				end else if (sres.old_ok) begin
					found_d = 1'b1;
					slot_d  = sres.old_idx;
					waddr   = sres.old_idx;
					want_we = 1'b1;
					nr_d    = sres.n_ready - CW'(1);
					nl_d    = sres.n_load + CW'(1);
				end else begin
					status_d = tslru_pkg::RS_FULL;
				end
			end
			tslru_pkg::FN_COMMIT: begin
				if (!idx_ok || sres.tgt_st != tslru_pkg::ST_LOADING) begin
					status_d = tslru_pkg::RS_ARG;
				end else begin
					want_we = 1'b1;
					wdata   = {tslru_pkg::ST_READY, tgt_key, frame_q};
					nl_d    = sres.n_load - CW'(1);
					nr_d    = sres.n_ready + CW'(1);
				end
			end
			tslru_pkg::FN_RELEASE: begin
				// a slot without its valid bit is free; key and stamp are dead
				if (!idx_ok || sres.tgt_st != tslru_pkg::ST_LOADING) begin
					status_d = tslru_pkg::RS_ARG;
				end else begin
					want_clr_one = 1'b1;
					nl_d         = sres.n_load - CW'(1);
					nf_d         = sres.n_free + CW'(1);
				end
			end
			tslru_pkg::FN_RESET: begin
				want_clr_all = 1'b1;
				nf_d         = n_act;
				nl_d         = '0;
				nr_d         = '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		mem_cmd.we      = fin_fire && want_we;
		mem_cmd.clr_one = fin_fire && want_clr_one;
		mem_cmd.clr_all = fin_fire && want_clr_all;
		mem_cmd.addr    = waddr;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (fin_fire)
			out_vld_q <= 1'b1;
		else if (m_axis_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			out_status_q <= status_d;
			out_found_q  <= found_d;
			out_slot_q   <= slot_d;
			out_free_q   <= nf_d;
			out_load_q   <= nl_d;
			out_ready_q  <= nr_d;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(tslru_pkg::OUT_W - RES_W){1'b0}}, out_ready_q, out_load_q,
	                        out_free_q, out_slot_q, out_found_q, out_status_q};

	// every slot in use is counted exactly once
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> ({2'b00, out_free_q} + {2'b00, out_load_q} + {2'b00, out_ready_q})
		              == {2'b00, n_act})
		else $error("slot counts do not add up to the slots in use");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_found_q) |-> (out_status_q == tslru_pkg::RS_OK))
		else $error("found result without ok status");

	a_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_found_q) |-> (out_slot_q == '0))
		else $error("slot number set without a find");

	a_wb_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_cmd.we || mem_cmd.clr_one || mem_cmd.clr_all) |-> (state_q == tslru_pkg::S_FINISH))
		else $error("slot memory written outside write-back");

endmodule

`default_nettype wire
